@@ rtl/core/gst_pkg.sv @@
package gst_pkg;

	// Table geometry
	localparam int SLOTS      = 256;
	localparam int SLOT_AW    = $clog2(SLOTS);
	localparam int SIZE_W     = SLOT_AW + 1;
	localparam int VALUE_W    = 64;
	localparam int OP_W       = 3;
	localparam int STATUS_W   = 2;

	// Occupancy scan: lanes checked per cycle (power of two)
	localparam int SCAN_LANES = 8;
	localparam int SCAN_SH    = $clog2(SCAN_LANES);

	// Command queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 2;
	localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	typedef enum logic [OP_W-1:0] {
		OPC_INSERT_AT   = 3'd0,
		OPC_INSERT_LAST = 3'd1,
		OPC_REMOVE_AT   = 3'd2,
		OPC_REMOVE_LAST = 3'd3,
		OPC_READ_AT     = 3'd4,
		OPC_READ_LAST   = 3'd5,
		OPC_NEXT_OCC    = 3'd6,
		OPC_RESIZE      = 3'd7
	} opcode_t;

	typedef enum logic [2:0] {
		CL_INSERT,
		CL_REMOVE,
		CL_READ,
		CL_NEXT,
		CL_RESIZE,
		CL_CLEAR
	} op_class_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_INVALID   = 2'd1,
		STS_CANCELLED = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GROWTH_MODE  = 2'd0,
		CFG_GROWTH_STEP  = 2'd1,
		CFG_MAX_SIZE     = 2'd2,
		CFG_INITIAL_SIZE = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_EVAL,
		BK_GROW,
		BK_WRITE,
		BK_SCAN,
		BK_READ
	} back_state_t;

	// Input transaction
	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [SLOT_AW-1:0] slot_index;
		logic [VALUE_W-1:0] entry_value;
		logic [SIZE_W-1:0]  size_request;
		logic               clear_flag;
	} gst_cmd_t;

	// Result transaction
	typedef struct packed {
		status_t            status;
		logic [VALUE_W-1:0] entry_out;
		logic [SIZE_W-1:0]  next_cursor;
		logic [SIZE_W-1:0]  size_out;
	} gst_result_t;

	// Classified command held in the queue
	typedef struct packed {
		op_class_t          op_class;
		logic               use_last;
		logic [SLOT_AW-1:0] slot_index;
		logic [VALUE_W-1:0] entry_value;
		logic [SIZE_W-1:0]  size_request;
	} gst_work_t;

	typedef struct packed {
		logic              growth_mode;
		logic [SIZE_W-1:0] growth_step;
		logic [SIZE_W-1:0] max_size;
		logic [SIZE_W-1:0] initial_size;
	} gst_cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} gst_q_status_t;

endpackage

@@ rtl/core/gst_front.sv @@
module gst_front
	import gst_pkg::*;
(
	input  logic          start,
	input  gst_cmd_t      command,
	output logic          busy,
	input  gst_q_status_t q_status,
	output logic          push,
	output gst_work_t     push_data
);

	// Accept while the queue has room
	assign busy = q_status.full;
	assign push = start && !q_status.full;

	// Classify the operation code
	always_comb begin
		push_data.op_class     = CL_INSERT;
		push_data.use_last     = 1'b0;
		push_data.slot_index   = command.slot_index;
		push_data.entry_value  = command.entry_value;
		push_data.size_request = command.size_request;
		unique case (opcode_t'(command.operation))
			OPC_INSERT_AT: begin
				push_data.op_class = CL_INSERT;
			end
			OPC_INSERT_LAST: begin
				push_data.op_class = CL_INSERT;
				push_data.use_last = 1'b1;
			end
			OPC_REMOVE_AT: begin
				push_data.op_class = CL_REMOVE;
			end
			OPC_REMOVE_LAST: begin
				push_data.op_class = CL_REMOVE;
				push_data.use_last = 1'b1;
			end
			OPC_READ_AT: begin
				push_data.op_class = CL_READ;
			end
			OPC_READ_LAST: begin
				push_data.op_class = CL_READ;
				push_data.use_last = 1'b1;
			end
			OPC_NEXT_OCC: begin
				push_data.op_class = CL_NEXT;
			end
			OPC_RESIZE: begin
				push_data.op_class = command.clear_flag ? CL_CLEAR : CL_RESIZE;
			end
			default: begin
				push_data.op_class = CL_RESIZE;
			end
		endcase
	end

endmodule

@@ rtl/core/gst_cmd_queue.sv @@
module gst_cmd_queue
	import gst_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gst_work_t     push_data,
	input  logic          pop,
	output gst_work_t     pop_data,
	output gst_q_status_t q_status
);

	gst_work_t           entries [QUEUE_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_PTR_W:0]    count_q;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (Q_PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (Q_PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data       = entries[rd_ptr_q];
	assign q_status.full  = (count_q == (Q_PTR_W+1)'(QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);

endmodule

@@ rtl/core/gst_back.sv @@
module gst_back
	import gst_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  gst_cfg_t      cfg,
	input  gst_q_status_t q_status,
	input  gst_work_t     pop_data,
	output logic          pop,
	output logic          done,
	output gst_result_t   result
);

	function automatic logic [SLOTS-1:0] size_mask(input logic [SIZE_W-1:0] n);
		logic [SLOTS-1:0] m;
		for (int i = 0; i < SLOTS; i++) begin
			m[i] = (SIZE_W'(i) < n);
		end
		return m;
	endfunction

	back_state_t         state_q, state_d;
	gst_work_t           work_q;
	logic [SIZE_W-1:0]   size_q, size_d;
	logic [SLOTS-1:0]    occ_q, occ_d;
	logic [VALUE_W-1:0]  mem [SLOTS];
	logic [VALUE_W-1:0]  rd_data_q;
	logic [SLOT_AW-1:0]  rd_addr;
	logic                mem_we;
	logic [SLOT_AW-1:0]  slot_q, slot_d;
	logic [SIZE_W:0]     grow_q, grow_d;
	logic [SLOT_AW-1:0]  ptr_q, ptr_d;
	logic [SIZE_W-1:0]   cursor_q, cursor_d;
	logic                done_q;
	gst_result_t         result_q;

	logic                finish;
	status_t             fin_status;
	logic [VALUE_W-1:0]  fin_entry;
	logic [SIZE_W-1:0]   fin_cursor;

	// Effective limits
	logic [SIZE_W-1:0]   lim;
	logic [SIZE_W-1:0]   step;
	logic                jump_max;
	assign lim      = (cfg.max_size < SIZE_W'(SLOTS)) ? cfg.max_size : SIZE_W'(SLOTS);
	assign step     = (cfg.growth_step == '0) ? SIZE_W'(1) : cfg.growth_step;
	assign jump_max = cfg.growth_mode && (step <= SIZE_W'(1));

	// Index resolution; last-slot ops at size zero wrap
	logic                idx_wrap;
	logic [SIZE_W-1:0]   idx_full;
	logic [SLOT_AW-1:0]  idx;
	logic                in_range;
	logic                ins_bad;
	logic                need_grow;
	logic                occ_at_idx;
	assign idx_wrap   = work_q.use_last && (size_q == '0);
	assign idx_full   = work_q.use_last ? (size_q - SIZE_W'(1)) : SIZE_W'(work_q.slot_index);
	assign idx        = idx_full[SLOT_AW-1:0];
	assign in_range   = !idx_wrap && (idx_full < size_q);
	assign ins_bad    = idx_wrap || (idx_full >= lim);
	assign need_grow  = (idx_full >= size_q) && !jump_max;
	assign occ_at_idx = occ_q[idx];

	// One growth step per cycle
	logic [2*SIZE_W-1:0] mul_res;
	logic [SIZE_W:0]     grow_next;
	logic                grow_more;
	logic [SIZE_W-1:0]   grow_final;
	always_comb begin
		mul_res = (grow_q == '0) ? (2*SIZE_W)'(step)
			: (2*SIZE_W)'(grow_q[SIZE_W-1:0]) * (2*SIZE_W)'(step);
		if (cfg.growth_mode) begin
			grow_next = (|mul_res[2*SIZE_W-1:SIZE_W+1]) ? '1 : mul_res[SIZE_W:0];
		end else begin
			grow_next = grow_q + (SIZE_W+1)'(step);
		end
	end
	assign grow_more  = ((SIZE_W+1)'(slot_q) >= grow_next) && (grow_next < (SIZE_W+1)'(lim));
	assign grow_final = (grow_next > (SIZE_W+1)'(lim)) ? lim : grow_next[SIZE_W-1:0];

	// Occupancy scan, one group of lanes per cycle
	logic [SIZE_W-1:0]     scan_base;
	logic [SIZE_W-1:0]     scan_end;
	logic                  scan_last;
	logic [SIZE_W-1:0]     lane_pos [SCAN_LANES];
	logic [SCAN_LANES-1:0] hit;
	logic                  hit_any;
	logic [SLOT_AW-1:0]    hit_pos;
	assign scan_base = (SIZE_W'(ptr_q) >> SCAN_SH) << SCAN_SH;
	assign scan_end  = scan_base + SIZE_W'(SCAN_LANES);
	assign scan_last = (scan_end >= size_q);
	always_comb begin
		for (int j = 0; j < SCAN_LANES; j++) begin
			lane_pos[j] = scan_base + SIZE_W'(j);
			hit[j] = (lane_pos[j] < size_q) && (lane_pos[j] >= SIZE_W'(ptr_q))
				&& occ_q[lane_pos[j][SLOT_AW-1:0]];
		end
	end
	assign hit_any = |hit;
	always_comb begin
		hit_pos = '0;
		for (int j = SCAN_LANES - 1; j >= 0; j--) begin
			if (hit[j]) begin
				hit_pos = lane_pos[j][SLOT_AW-1:0];
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_status.empty) begin
					state_d = BK_EVAL;
				end
			end
			BK_EVAL: begin
				unique case (work_q.op_class)
					CL_INSERT: begin
						if (ins_bad) begin
							state_d = BK_IDLE;
						end else if (need_grow) begin
							state_d = BK_GROW;
						end else begin
							state_d = BK_WRITE;
						end
					end
					CL_READ: begin
						state_d = (in_range && occ_at_idx) ? BK_READ : BK_IDLE;
					end
					CL_NEXT: begin
						state_d = (SIZE_W'(work_q.slot_index) < size_q) ? BK_SCAN : BK_IDLE;
					end
					default: state_d = BK_IDLE;
				endcase
			end
			BK_GROW:  state_d = grow_more ? BK_GROW : BK_WRITE;
			BK_WRITE: state_d = BK_IDLE;
			BK_SCAN: begin
				if (hit_any) begin
					state_d = BK_READ;
				end else if (scan_last) begin
					state_d = BK_IDLE;
				end
			end
			BK_READ:  state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	// Datapath control
	always_comb begin
		pop        = 1'b0;
		finish     = 1'b0;
		fin_status = STS_OK;
		fin_entry  = '0;
		fin_cursor = '0;
		size_d     = size_q;
		occ_d      = occ_q;
		mem_we     = 1'b0;
		rd_addr    = slot_q;
		slot_d     = slot_q;
		grow_d     = grow_q;
		ptr_d      = ptr_q;
		cursor_d   = cursor_q;
		unique case (state_q)
			BK_IDLE: begin
				pop = !q_status.empty;
			end
			BK_EVAL: begin
				slot_d  = idx;
				rd_addr = idx;
				unique case (work_q.op_class)
					CL_INSERT: begin
						if (ins_bad) begin
							finish     = 1'b1;
							fin_status = STS_INVALID;
						end else if (idx_full >= size_q) begin
							if (jump_max) begin
								size_d = lim;
							end else begin
								grow_d = (SIZE_W+1)'(size_q);
							end
						end
					end
					CL_REMOVE: begin
						finish = 1'b1;
						if (!in_range) begin
							fin_status = STS_INVALID;
						end else if (!occ_at_idx) begin
							fin_status = STS_CANCELLED;
						end else begin
							occ_d[idx] = 1'b0;
						end
					end
					CL_READ: begin
						cursor_d = '0;
						if (!in_range) begin
							finish     = 1'b1;
							fin_status = STS_INVALID;
						end else if (!occ_at_idx) begin
							finish     = 1'b1;
							fin_status = STS_CANCELLED;
						end
					end
					CL_NEXT: begin
						ptr_d = work_q.slot_index;
						if (SIZE_W'(work_q.slot_index) >= size_q) begin
							finish     = 1'b1;
							fin_status = STS_CANCELLED;
							fin_cursor = size_q;
						end
					end
					CL_RESIZE: begin
						finish = 1'b1;
						if (work_q.size_request > lim) begin
							fin_status = STS_INVALID;
						end else begin
							size_d = work_q.size_request;
							occ_d  = occ_q & size_mask(work_q.size_request);
						end
					end
					CL_CLEAR: begin
						finish = 1'b1;
						occ_d  = '0;
						size_d = (cfg.initial_size > lim) ? lim : cfg.initial_size;
					end
					default: begin
						finish     = 1'b1;
						fin_status = STS_INVALID;
					end
				endcase
			end
			BK_GROW: begin
				grow_d = grow_next;
				if (!grow_more) begin
					size_d = grow_final;
				end
			end
			BK_WRITE: begin
				finish = 1'b1;
				if (occ_q[slot_q]) begin
					fin_status = STS_CANCELLED;
				end else begin
					mem_we        = 1'b1;
					occ_d[slot_q] = |work_q.entry_value;
				end
			end
			BK_SCAN: begin
				if (hit_any) begin
					slot_d   = hit_pos;
					rd_addr  = hit_pos;
					cursor_d = SIZE_W'(hit_pos) + SIZE_W'(1);
				end else if (scan_last) begin
					finish     = 1'b1;
					fin_status = STS_CANCELLED;
					fin_cursor = size_q;
				end else begin
					ptr_d = scan_end[SLOT_AW-1:0];
				end
			end
			BK_READ: begin
				finish     = 1'b1;
				fin_entry  = rd_data_q;
				fin_cursor = cursor_q;
			end
			default: begin
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			size_q  <= '0;
			occ_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			size_q  <= size_d;
			occ_q   <= occ_d;
			done_q  <= finish;
		end
	end

	// Working registers and result register
	always_ff @(posedge clk) begin
		if (pop) begin
			work_q <= pop_data;
		end
		slot_q   <= slot_d;
		grow_q   <= grow_d;
		ptr_q    <= ptr_d;
		cursor_q <= cursor_d;
		if (finish) begin
			result_q.status      <= fin_status;
			result_q.entry_out   <= fin_entry;
			result_q.next_cursor <= fin_cursor;
			result_q.size_out    <= size_d;
		end
	end

	// Slot memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[slot_q] <= work_q.entry_value;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign done   = done_q;
	assign result = result_q;

	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		size_q <= SIZE_W'(SLOTS))
		else $error("logical size above slot count");

	a_empty_above: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q & ~size_mask(size_q)) == '0)
		else $error("occupied slot at or above logical size");

	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !occ_q[slot_q])
		else $error("insert overwrote an occupied slot");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe on back-to-back cycles");

	a_grow_target: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_GROW) |-> (SIZE_W'(slot_q) >= size_q))
		else $error("growing while target slot already fits");

endmodule

@@ rtl/core/growable_slot_table_top.sv @@
// Flow: the execution unit pops a command in IDLE and evaluates it in EVAL, where remove,
// resize, clear, invalid inserts, failed reads and out-of-range next_occupied finish. Other
// inserts go to WRITE, through GROW a growth step at a time when the table must grow; reads
// finish in READ; next_occupied scans groups of 8 slots in SCAN and goes to READ on a hit.
// A 2-entry command queue absorbs starts, and busy is high only when it is full.
// Reset: arst_n empties the table, zeroes the size, restores config; receiver never stalls.
module growable_slot_table_top
	import gst_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  gst_cmd_t              command,
	output logic                  busy,
	output logic                  done,
	output gst_result_t           result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	gst_cfg_t      cfg_q;
	gst_q_status_t q_status;
	logic          push;
	logic          pop;
	gst_work_t     push_data;
	gst_work_t     pop_data;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.growth_mode  <= 1'b0;
			cfg_q.growth_step  <= SIZE_W'(1);
			cfg_q.max_size     <= SIZE_W'(SLOTS);
			cfg_q.initial_size <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_GROWTH_MODE:  cfg_q.growth_mode  <= cfg_data[0];
				CFG_GROWTH_STEP:  cfg_q.growth_step  <= cfg_data[SIZE_W-1:0];
				CFG_MAX_SIZE:     cfg_q.max_size     <= cfg_data[SIZE_W-1:0];
				CFG_INITIAL_SIZE: cfg_q.initial_size <= cfg_data[SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	gst_front u_front (
		.start     (start),
		.command   (command),
		.busy      (busy),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	gst_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_status  (q_status)
	);

	gst_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_status (q_status),
		.pop_data (pop_data),
		.pop      (pop),
		.done     (done),
		.result   (result)
	);

endmodule

@@ bench/growable_slot_table_top_tb.sv @@
import gst_pkg::*;

// Predicts the slot table and checks each result transaction in order
class slot_table_mirror;
	logic [VALUE_W-1:0] slots [SLOTS];
	int unsigned tbl_size;
	int unsigned grow_mode;
	int unsigned grow_step;
	int unsigned max_size;
	int unsigned init_size;
	gst_result_t expected_q[$];
	int unsigned mismatches;

	function new();
		foreach (slots[i]) slots[i] = '0;
		tbl_size   = 0;
		grow_mode  = 0;
		grow_step  = 1;
		max_size   = 256;
		init_size  = 0;
		mismatches = 0;
	endfunction

	function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
		case (idx)
			CFG_GROWTH_MODE:  grow_mode = v[0];
			CFG_GROWTH_STEP:  grow_step = v;
			CFG_MAX_SIZE:     max_size  = v;
			CFG_INITIAL_SIZE: init_size = v;
			default: ;
		endcase
	endfunction

	// The size cap is max_size clamped to the physical table
	function int unsigned size_cap();
		return (max_size < SLOTS) ? max_size : SLOTS;
	endfunction

	// Slots at and above the new size are emptied on a shrink
	function void apply_size(int unsigned n);
		for (int unsigned i = n; i < tbl_size && i < SLOTS; i++) slots[i] = '0;
		tbl_size = n;
	endfunction

	function int unsigned grown_size(int unsigned index);
		int unsigned lim;
		int unsigned stp;
		int unsigned n;
		lim = size_cap();
		stp = (grow_step == 0) ? 1 : grow_step;
		n   = tbl_size;
		if (grow_mode == 0) begin
			do n += stp; while (index >= n && n < lim);
		end else if (stp <= 1) begin
			// factor one cannot grow, so jump to the cap
			n = lim;
		end else begin
			n = (n != 0) ? n * stp : stp;
			while (index >= n && n < lim) n *= stp;
		end
		return (n > lim) ? lim : n;
	endfunction

	function gst_result_t predict(gst_cmd_t c);
		gst_result_t r;
		int unsigned i;
		int unsigned last;
		r.status      = STS_OK;
		r.entry_out   = '0;
		r.next_cursor = '0;
		// wraps to a huge index at size zero, failing every bound check
		last = tbl_size - 1;
		case (opcode_t'(c.operation))
			OPC_INSERT_AT, OPC_INSERT_LAST: begin
				i = (c.operation == OPC_INSERT_AT) ? c.slot_index : last;
				if (i >= size_cap()) begin
					r.status = STS_INVALID;
				end else begin
					if (i >= tbl_size) apply_size(grown_size(i));
					if (slots[i] != 0) r.status = STS_CANCELLED;
					else slots[i] = c.entry_value;
				end
			end
			OPC_REMOVE_AT, OPC_REMOVE_LAST: begin
				i = (c.operation == OPC_REMOVE_AT) ? c.slot_index : last;
				if (i >= tbl_size || i >= SLOTS) r.status = STS_INVALID;
				else if (slots[i] == 0) r.status = STS_CANCELLED;
				else slots[i] = '0;
			end
			OPC_READ_AT, OPC_READ_LAST: begin
				i = (c.operation == OPC_READ_AT) ? c.slot_index : last;
				if (i >= tbl_size || i >= SLOTS) r.status = STS_INVALID;
				else if (slots[i] == 0) r.status = STS_CANCELLED;
				else r.entry_out = slots[i];
			end
			OPC_NEXT_OCC: begin
				r.status      = STS_CANCELLED;
				r.next_cursor = SIZE_W'(tbl_size);
				for (i = c.slot_index; i < tbl_size && i < SLOTS && r.status != STS_OK; i++) begin
					if (slots[i] != 0) begin
						r.entry_out   = slots[i];
						r.next_cursor = SIZE_W'(i + 1);
						r.status      = STS_OK;
					end
				end
			end
			default: begin
				if (c.clear_flag) begin
					foreach (slots[k]) slots[k] = '0;
					tbl_size = (init_size > size_cap()) ? size_cap() : init_size;
				end else if (c.size_request > size_cap()) begin
					r.status = STS_INVALID;
				end else begin
					apply_size(c.size_request);
				end
			end
		endcase
		r.size_out = SIZE_W'(tbl_size);
		return r;
	endfunction

	function void log_command(gst_cmd_t c);
		expected_q.push_back(predict(c));
	endfunction

	function void match_result(gst_result_t got);
		gst_result_t want;
		if (expected_q.size() == 0) begin
			$error("result with no command outstanding, status %0d", got.status);
			mismatches++;
			return;
		end
		want = expected_q.pop_front();
		if (got.status !== want.status) begin
			$error("status expected %0d actual %0d", want.status, got.status);
			mismatches++;
		end
		if (got.entry_out !== want.entry_out) begin
			$error("entry_out expected %h actual %h", want.entry_out, got.entry_out);
			mismatches++;
		end
		if (got.next_cursor !== want.next_cursor) begin
			$error("next_cursor expected %0d actual %0d", want.next_cursor, got.next_cursor);
			mismatches++;
		end
		if (got.size_out !== want.size_out) begin
			$error("size_out expected %0d actual %0d", want.size_out, got.size_out);
			mismatches++;
		end
	endfunction
endclass

module growable_slot_table_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int unsigned PHASES      = 10;
	localparam int unsigned PHASE_ITEMS = 200;
	localparam int unsigned SETTLE      = 300;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	gst_cmd_t              command;
	logic                  busy;
	logic                  done;
	gst_result_t           result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	slot_table_mirror mirror = new();
	int unsigned cycle_count = 0;
	bit quiet;

	// Register settings per phase; phase 0 runs on reset defaults
	int unsigned phase_mode [PHASES] = '{0, 0, 1, 1, 0, 1, 0, 1, 1, 0};
	int unsigned phase_step [PHASES] = '{1, 4, 2, 1, 256, 0, 0, 3, 256, 0};
	int unsigned phase_max  [PHASES] = '{256, 64, 256, 100, 256, 200, 1, 511, 37, 0};
	int unsigned phase_init [PHASES] = '{0, 8, 1, 0, 256, 16, 5, 300, 2, 0};

	growable_slot_table_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.command   (command),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && done) mirror.match_result(result);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (quiet || r < 5) return 0;
		if (r < 9) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic gst_cmd_t make_cmd(opcode_t op, int unsigned idx,
			logic [VALUE_W-1:0] val, int unsigned req, bit clr);
		gst_cmd_t c;
		c.operation    = op;
		c.slot_index   = SLOT_AW'(idx);
		c.entry_value  = val;
		c.size_request = SIZE_W'(req);
		c.clear_flag   = clr;
		return c;
	endfunction

	// Mostly addresses near the occupied region so inserts, reads and removes hit
	function automatic gst_cmd_t random_command();
		gst_cmd_t c;
		int unsigned pick;
		int unsigned sz;
		int unsigned hi;
		int unsigned v;
		int unsigned cap;
		sz  = mirror.tbl_size;
		cap = mirror.size_cap();
		hi  = (sz + 6 > 255) ? 255 : sz + 6;
		c.slot_index   = SLOT_AW'($urandom);
		c.entry_value  = {$urandom, $urandom};
		c.size_request = SIZE_W'($urandom_range(0, 256));
		c.clear_flag   = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 30)      c.operation = OPC_INSERT_AT;
		else if (pick < 38) c.operation = OPC_INSERT_LAST;
		else if (pick < 50) c.operation = OPC_REMOVE_AT;
		else if (pick < 55) c.operation = OPC_REMOVE_LAST;
		else if (pick < 70) c.operation = OPC_READ_AT;
		else if (pick < 75) c.operation = OPC_READ_LAST;
		else if (pick < 87) c.operation = OPC_NEXT_OCC;
		else                c.operation = OPC_RESIZE;
		if ($urandom_range(0, 9) < 8) c.slot_index = SLOT_AW'($urandom_range(0, hi));
		if ((c.operation == OPC_REMOVE_AT || c.operation == OPC_READ_AT) && sz > 0
				&& $urandom_range(0, 9) < 7)
			c.slot_index = SLOT_AW'($urandom_range(0, (sz > 256) ? 255 : sz - 1));
		v = $urandom_range(0, 19);
		if (v == 0) c.entry_value = '0;
		else if (v == 1) c.entry_value = '1;
		if (c.operation == OPC_RESIZE) begin
			c.clear_flag = ($urandom_range(0, 4) == 0);
			v = $urandom_range(0, 9);
			if (v < 6)      c.size_request = SIZE_W'($urandom_range(0, 48));
			else if (v < 8) c.size_request = SIZE_W'($urandom_range(0, 256));
			else            c.size_request = SIZE_W'((cap < 256) ? cap + $urandom_range(0, 1) : cap);
		end
		return c;
	endfunction

	// Drive one command transaction; start stays high unless a gap follows
	task automatic issue(gst_cmd_t c, int unsigned gap);
		start   <= 1'b1;
		command <= c;
		do @(posedge clk); while (busy);
		mirror.log_command(c);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off new commands until every outstanding result is back
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (mirror.expected_q.size() != 0);
	endtask

	task automatic write_cfg(cfg_reg_t idx, int unsigned v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(v);
		do @(posedge clk); while (!cfg_ready);
		mirror.set_register(idx, CFG_DATA_W'(v));
	endtask

	// Corner cases on the reset configuration: additive step one, cap 256
	task automatic run_directed();
		issue(make_cmd(OPC_READ_LAST, 0, '0, 0, 0), pick_gap());
		issue(make_cmd(OPC_REMOVE_LAST, 0, '0, 0, 0), pick_gap());
		issue(make_cmd(OPC_INSERT_LAST, 0, 64'h1, 0, 0), pick_gap());
		issue(make_cmd(OPC_NEXT_OCC, 0, '0, 0, 0), pick_gap());
		issue(make_cmd(OPC_INSERT_AT, 3, '1, 0, 0), pick_gap());
		issue(make_cmd(OPC_INSERT_AT, 3, 64'h5, 0, 0), pick_gap());
		issue(make_cmd(OPC_INSERT_AT, 1, '0, 0, 0), pick_gap());
		issue(make_cmd(OPC_READ_AT, 1, '0, 0, 0), pick_gap());
		issue(make_cmd(OPC_REMOVE_AT, 1, '0, 0, 0), pick_gap());
		issue(make_cmd(OPC_READ_AT, 3, '0, 0, 0), pick_gap());
		issue(make_cmd(OPC_READ_AT, 255, '0, 0, 0), pick_gap());
		issue(make_cmd(OPC_REMOVE_AT, 4, '0, 0, 0), pick_gap());
		issue(make_cmd(OPC_NEXT_OCC, 0, '0, 0, 0), pick_gap());
		issue(make_cmd(OPC_NEXT_OCC, 4, '0, 0, 0), pick_gap());
		issue(make_cmd(OPC_INSERT_LAST, 0, 64'h7, 0, 0), pick_gap());
		issue(make_cmd(OPC_READ_LAST, 0, '0, 0, 0), pick_gap());
		issue(make_cmd(OPC_REMOVE_LAST, 0, '0, 0, 0), pick_gap());
		issue(make_cmd(OPC_RESIZE, 0, '0, 256, 0), pick_gap());
		issue(make_cmd(OPC_INSERT_AT, 255, 64'h8000_0000_0000_0001, 0, 0), pick_gap());
		issue(make_cmd(OPC_NEXT_OCC, 200, '0, 0, 0), pick_gap());
		issue(make_cmd(OPC_RESIZE, 0, '0, 2, 0), pick_gap());
		issue(make_cmd(OPC_RESIZE, 0, '0, 10, 0), pick_gap());
		issue(make_cmd(OPC_READ_AT, 5, '0, 0, 0), pick_gap());
		issue(make_cmd(OPC_RESIZE, 0, '0, 300 % 512, 1), pick_gap());
		// additive growth one slot at a time, all the way to the cap
		issue(make_cmd(OPC_INSERT_AT, 255, '1, 0, 0), pick_gap());
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		command   = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_GROWTH_MODE;
		cfg_data  = '0;
		quiet     = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			if (ph == 0) begin
				run_directed();
			end else begin
				if (ph == PHASES - 1) begin
					phase_mode[ph] = $urandom_range(0, 1);
					phase_step[ph] = $urandom_range(0, 256);
					phase_max[ph]  = $urandom_range(1, 256);
					phase_init[ph] = $urandom_range(0, 256);
				end
				// registers change only with nothing in flight
				drain();
				write_cfg(CFG_GROWTH_MODE, phase_mode[ph]);
				write_cfg(CFG_GROWTH_STEP, phase_step[ph]);
				write_cfg(CFG_MAX_SIZE, phase_max[ph]);
				write_cfg(CFG_INITIAL_SIZE, phase_init[ph]);
				cfg_valid <= 1'b0;
			end
			issue(make_cmd(OPC_RESIZE, 0, '0, 0, 1), pick_gap());
			for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 50 == 0) quiet = ($urandom_range(0, 2) == 0);
				if ($urandom_range(0, 99) == 0) drain();
				issue(random_command(), pick_gap());
			end
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.expected_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
